// ===== hdl/wmtf_pkg.sv =====
package wmtf_pkg;

  // Storage sizing.
  localparam int MAX_ITEMS   = 512;
  localparam int WEIGHT_BITS = 16;
  localparam int ID_BITS     = $clog2(MAX_ITEMS);

  // Fixed field widths of the stream payloads.
  localparam int FIELD_ID_W  = 9;
  localparam int FIELD_WT_W  = 16;
  localparam int COST_W      = 25;
  localparam int TOTAL_W     = 48;

  localparam int IN_TDATA_W  = ((FIELD_ID_W + FIELD_WT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((COST_W + TOTAL_W + 7) / 8) * 8;

  // Wide enough for the weights of every entry above the deepest one.
  localparam int SUM_BITS = (WEIGHT_BITS + ID_BITS > COST_W) ? WEIGHT_BITS + ID_BITS : COST_W;

  localparam logic [SUM_BITS-1:0] COST_LIMIT = SUM_BITS'({COST_W{1'b1}});
  localparam logic [ID_BITS-1:0]  LAST_STEP  = ID_BITS'(MAX_ITEMS - 1);

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_PUBLISH
  } state_t;

  // One stack position.
  typedef struct packed {
    logic               valid;
    logic [ID_BITS-1:0] id;
  } entry_t;

  // Control from the sequencer to the weight store and adder.
  typedef struct packed {
    logic                   clear;
    logic                   rd_en;
    logic [ID_BITS-1:0]     rd_addr;
    logic                   wr_en;
    logic [ID_BITS-1:0]     wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
  } acc_ctl_t;

endpackage

// ===== hdl/wmtf_cell.sv =====
module wmtf_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  wmtf_pkg::entry_t nxt,
  output wmtf_pkg::entry_t cur
);
  import wmtf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (shift) begin
      cur <= nxt;
    end
  end

endmodule

// ===== hdl/wmtf_accum.sv =====
module wmtf_accum (
  input  logic                           clk,
  input  logic                           rst,
  input  wmtf_pkg::acc_ctl_t             ctl,
  output logic [wmtf_pkg::SUM_BITS-1:0]  sum
);
  import wmtf_pkg::*;

  logic [WEIGHT_BITS-1:0] wmem [MAX_ITEMS];
  logic [WEIGHT_BITS-1:0] rd_data;
  logic                   pend;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      wmem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= wmem[ctl.rd_addr];
    end
  end

  // The read data is registered and arrives in the cycle after the address, so the add trails the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      sum  <= '0;
    end else begin
      pend <= ctl.rd_en;
      if (ctl.clear) begin
        sum <= '0;
      end else if (pend) begin
        sum <= sum + SUM_BITS'(rd_data);
      end
    end
  end

endmodule

// ===== hdl/weighted_move_to_front_stack.sv =====
// Weighted move-to-front stack.
// Input channel s_axis: tuser selects a weight load or a request, tdata carries the
// item id and the weight, tlast marks the final request of a sequence.
// Output channel m_axis: one transaction per request, carrying the weight sum of the
// entries above the requested id, the saturating running total, and tlast echoed.
// Loads produce no output transaction; the input stays ready, so loads can follow
// each other in consecutive cycles.
// A request rotates the whole row of stack cells through the top cell once, one
// position per cycle, in the walk state; a drain state then takes the final weight
// add, and a publish state moves the result into the output register. The input
// takes the next item once the publish is done. The single read port of the weight
// memory is fed from the top cell.
// While a request is in progress the input is not ready; a finished result sits in the
// output register, so the next item can be accepted while the receiver stalls. A second
// result waits inside the block until the output register is free.
// Reset empties the stack and clears the running total. The weight memory is not
// cleared; requesting an id whose weight was never loaded gives an undefined cost.
module weighted_move_to_front_stack (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [wmtf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // item_id, item_weight
  input  logic                             s_axis_tlast,   // last_request
  input  logic                             s_axis_tuser,   // op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [wmtf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // request_cost, running_total
  output logic                             m_axis_tlast    // sequence_done
);
  import wmtf_pkg::*;

  state_t                 state, state_next;
  logic [ID_BITS-1:0]     cnt;
  logic [ID_BITS-1:0]     target;
  logic                   last_flag;
  entry_t                 hold;
  logic                   found;

  logic                   out_valid;
  logic [COST_W-1:0]      out_cost;
  logic [TOTAL_W-1:0]     out_total;
  logic                   out_last;
  logic [TOTAL_W-1:0]     total;

  entry_t                 chain [MAX_ITEMS];
  entry_t                 tail;
  entry_t                 top;
  logic                   shift;
  logic                   hit;
  logic                   load_out;
  acc_ctl_t               ctl;
  logic [SUM_BITS-1:0]    acc_sum;

  logic                   s_fire;
  logic [FIELD_ID_W-1:0]  in_id_field;
  logic [FIELD_WT_W-1:0]  in_wt_field;
  logic [ID_BITS-1:0]     in_id;
  logic                   id_ok;
  logic [TOTAL_W:0]       total_sum;
  logic [TOTAL_W-1:0]     total_next;
  logic [COST_W-1:0]      cost_sat;

  assign in_id_field = s_axis_tdata[FIELD_ID_W-1:0];
  assign in_wt_field = s_axis_tdata[FIELD_ID_W +: FIELD_WT_W];
  assign in_id       = ID_BITS'(in_id_field);
  assign id_ok       = int'(in_id_field) < MAX_ITEMS;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign top = chain[0];
  // The top entry leaves the walk at the requested id, or at the first empty cell
  // when the id is not yet on the stack.
  assign hit = !found && (!top.valid || (top.id == target));

  // Until the hit, the stream to the tail runs one entry late through the hold
  // register, which starts with the requested id; the hit entry is dropped.
  assign tail = found ? top : hold;

  generate
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      entry_t nxt;
      if (i == MAX_ITEMS - 1) begin : g_end
        assign nxt = tail;
      end else begin : g_mid
        assign nxt = chain[i+1];
      end
      wmtf_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .nxt   (nxt),
        .cur   (chain[i])
      );
    end
  endgenerate

  wmtf_accum u_accum (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sum (acc_sum)
  );

  always_comb begin
    state_next  = state;
    shift       = 1'b0;
    load_out    = 1'b0;
    ctl         = '0;
    ctl.rd_addr = top.id;
    ctl.wr_addr = in_id;
    ctl.wr_data = WEIGHT_BITS'(in_wt_field);
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser == OP_LOAD) begin
            ctl.wr_en = id_ok;
          end else begin
            ctl.clear  = 1'b1;
            state_next = id_ok ? ST_WALK : ST_PUBLISH;
          end
        end
      end
      ST_WALK: begin
        shift     = 1'b1;
        ctl.rd_en = !found && !hit;
        if (cnt == LAST_STEP) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (!out_valid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign total_sum  = (TOTAL_W+1)'(total) + (TOTAL_W+1)'(acc_sum);
  assign total_next = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
  assign cost_sat   = (acc_sum > COST_LIMIT) ? {COST_W{1'b1}} : COST_W'(acc_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
      found     <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
        total     <= total_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (s_fire && s_axis_tuser == OP_REQUEST) begin
        found <= 1'b0;
        cnt   <= '0;
      end else if (state == ST_WALK) begin
        found <= found | hit;
        cnt   <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_axis_tuser == OP_REQUEST) begin
      target    <= in_id;
      last_flag <= s_axis_tlast;
      hold      <= '{valid: 1'b1, id: in_id};
    end else if (state == ST_WALK && !found && !hit) begin
      hold <= top;
    end
    if (load_out) begin
      out_cost  <= cost_sat;
      out_total <= total_next;
      out_last  <= last_flag;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_TDATA_W - COST_W - TOTAL_W)'(0), out_total, out_cost};
  assign m_axis_tlast  = out_last;

endmodule

// ===== hdl/wmtf_checker.sv =====
module wmtf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [wmtf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import wmtf_pkg::*;

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  // A weight load leaves the input ready.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD |=> s_axis_tready)
    else $error("input not ready after a weight load");

  // The running total already includes the cost it is reported with.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[COST_W +: TOTAL_W] >= TOTAL_W'(m_axis_tdata[COST_W-1:0]))
    else $error("running total below request cost");

endmodule

bind weighted_move_to_front_stack wmtf_checker u_wmtf_checker (.*);
